// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PTE_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`define PTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define PTE_ASSERT_NEVER(label, clk, rst_n, expr)
`define PTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Types and constants of the permission table engine.
// ----------------------------------------------------------------------------
package pte_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    CMD_SAVE      = 3'd0,
    CMD_DEL_ID    = 3'd1,
    CMD_DEL_USER  = 3'd2,
    CMD_FIND_LOC  = 3'd3,
    CMD_FIND_USER = 3'd4,
    CMD_CLEAR     = 3'd5,
    CMD_ALLOC     = 3'd6,
    CMD_READ      = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_ALLOC
  } state_e;

  typedef struct packed {
    logic        backup;
    logic [15:0] local_id;
    logic [15:0] fp_id;
    logic [31:0] user;
    logic [31:0] expire;
    logic [7:0]  role;
    logic [3:0]  lock;
  } entry_t;

endpackage

// File: sv/permission_table_engine.sv
// ----------------------------------------------------------------------------
// permission_table_engine
// Permission table in one single-port-write RAM, scanned by a sequencer.
// ----------------------------------------------------------------------------
// Each scanned entry passes through ST_RD (RAM read), then ST_CHK (check/write).
// Find, save and delete scan at most count entries; allocate scans count entries,
// then searches for a free ID in ST_ALLOC; read visits at most one entry; clear needs no scan.
// One transaction is in flight at a time.
// Reset clears count, version and handshake state; table RAM is not cleared.
module permission_table_engine
  import pte_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic signed [15:0] fingerprint_id_i,
  input  logic [31:0]        user_number_i,
  input  logic [3:0]         lock_mask_i,
  input  logic [7:0]         role_code_i,
  input  logic [31:0]        expire_days_i,
  input  logic signed [15:0] local_fingerprint_id_i,
  input  logic               backup_i,
  input  logic [31:0]        version_i,
  input  logic [5:0]         entry_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ok_o,
  output logic               found_o,
  output logic signed [15:0] out_fingerprint_id_o,
  output logic [31:0]        out_user_number_o,
  output logic [3:0]         out_lock_mask_o,
  output logic [7:0]         out_role_code_o,
  output logic [31:0]        out_expire_days_o,
  output logic signed [15:0] out_local_id_o,
  output logic               out_backup_o,
  output logic [6:0]         entry_count_out_o,
  output logic [31:0]        version_out_o,
  output logic signed [6:0]  allocated_id_o
);

  `include "assert_macros.svh"

  entry_t mem [MAX_ENTRIES];
  entry_t rdata_q;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  state_e state_q, state_d;
  cmd_e   cmd_q;
  entry_t new_q;
  logic [31:0] ver_q;

  logic [CW-1:0] idx_q, idx_d, outp_q, outp_d, count_q, count_d;
  logic          shift_q, shift_d;
  logic [MAX_ENTRIES-1:0] used_q, used_d;
  logic [CW-1:0] aid_q, aid_d;
  logic [31:0]   version_q, version_d;
  logic          out_valid_q, out_valid_d, ok_q, ok_d, found_q, found_d;
  entry_t        res_q, res_d;
  logic [6:0]    alloc_q, alloc_d;
  logic          accept;

  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(command_i);
      new_q <= '{backup: backup_i, local_id: local_fingerprint_id_i,
                 fp_id: fingerprint_id_i, user: user_number_i,
                 expire: expire_days_i, role: role_code_i, lock: lock_mask_i};
      ver_q <= version_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      outp_q      <= '0;
      shift_q     <= 1'b0;
      used_q      <= '0;
      aid_q       <= '0;
      count_q     <= '0;
      version_q   <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      found_q     <= 1'b0;
      res_q       <= '0;
      alloc_q     <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      outp_q      <= outp_d;
      shift_q     <= shift_d;
      used_q      <= used_d;
      aid_q       <= aid_d;
      count_q     <= count_d;
      version_q   <= version_d;
      out_valid_q <= out_valid_d;
      ok_q        <= ok_d;
      found_q     <= found_d;
      res_q       <= res_d;
      alloc_q     <= alloc_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    outp_d      = outp_q;
    shift_d     = shift_q;
    used_d      = used_q;
    aid_d       = aid_q;
    count_d     = count_q;
    version_d   = version_q;
    out_valid_d = out_valid_q;
    ok_d        = ok_q;
    found_d     = found_q;
    res_d       = res_q;
    alloc_d     = alloc_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[IW-1:0];
    mem_wdata   = rdata_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ok_d    = 1'b1;
          found_d = 1'b0;
          res_d   = '0;
          alloc_d = '0;
          outp_d  = '0;
          shift_d = 1'b0;
          used_d  = '0;
          aid_d   = CW'(1);
          idx_d   = (cmd_e'(command_i) == CMD_READ) ? CW'(entry_index_i) : '0;
          if (cmd_e'(command_i) == CMD_CLEAR) begin
            count_d     = '0;
            version_d   = '0;
            out_valid_d = 1'b1;
          end else begin
            state_d = ST_RD;
          end
        end
      end

      ST_RD: begin
        if (idx_q < count_q) begin
          state_d = ST_CHK;
        end else begin
          // scan ran off the end of the table
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          case (cmd_q)
            CMD_SAVE: begin
              if (count_q >= CW'(MAX_ENTRIES)) begin
                ok_d = 1'b0;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IW-1:0];
                mem_wdata = new_q;
                count_d   = count_q + CW'(1);
                if (ver_q != '0) version_d = ver_q;
              end
            end
            CMD_DEL_ID: begin
              if (shift_q) begin
                count_d = count_q - CW'(1);
                found_d = 1'b1;
              end
            end
            CMD_DEL_USER: begin
              count_d = outp_q;
              found_d = (outp_q != count_q);
              if (ver_q != '0) version_d = ver_q;
            end
            CMD_ALLOC: begin
              state_d     = ST_ALLOC;
              out_valid_d = 1'b0;
            end
            default: ;
          endcase
        end
      end

      ST_CHK: begin
        state_d = ST_RD;
        idx_d   = idx_q + CW'(1);
        case (cmd_q) inside
          CMD_SAVE: begin
            if (rdata_q.local_id == new_q.local_id) begin
              mem_we      = 1'b1;
              mem_wdata   = new_q;
              found_d     = 1'b1;
              if (ver_q != '0) version_d = ver_q;
              state_d     = ST_IDLE;
              out_valid_d = 1'b1;
            end
          end
          CMD_DEL_ID: begin
            if (shift_q) begin
              mem_we    = 1'b1;
              mem_waddr = IW'(idx_q - CW'(1));
            end else if (rdata_q.fp_id == new_q.fp_id ||
                         rdata_q.local_id == new_q.fp_id) begin
              shift_d = 1'b1;
            end
          end
          CMD_DEL_USER: begin
            if (rdata_q.user != new_q.user) begin
              mem_we    = 1'b1;
              mem_waddr = outp_q[IW-1:0];
              outp_d    = outp_q + CW'(1);
            end
          end
          CMD_FIND_LOC, CMD_FIND_USER, CMD_READ: begin
            if ((cmd_q == CMD_READ) ||
                (cmd_q == CMD_FIND_LOC && rdata_q.local_id == new_q.local_id) ||
                (cmd_q == CMD_FIND_USER && !rdata_q.backup &&
                 rdata_q.user == new_q.user)) begin
              found_d     = 1'b1;
              res_d       = rdata_q;
              state_d     = ST_IDLE;
              out_valid_d = 1'b1;
            end
          end
          CMD_ALLOC: begin
            if (rdata_q.local_id < 16'(MAX_ENTRIES)) begin
              used_d[rdata_q.local_id[IW-1:0]] = 1'b1;
            end
          end
          default: ;
        endcase
      end

      ST_ALLOC: begin
        if (aid_q >= CW'(MAX_ENTRIES)) begin
          alloc_d     = '1;
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end else if (!used_q[aid_q[IW-1:0]]) begin
          found_d     = 1'b1;
          alloc_d     = 7'(aid_q);
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end else begin
          aid_d = aid_q + CW'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o          = out_valid_q;
  assign ok_o                 = ok_q;
  assign found_o              = found_q;
  assign out_fingerprint_id_o = res_q.fp_id;
  assign out_user_number_o    = res_q.user;
  assign out_lock_mask_o      = res_q.lock;
  assign out_role_code_o      = res_q.role;
  assign out_expire_days_o    = res_q.expire;
  assign out_local_id_o       = res_q.local_id;
  assign out_backup_o         = res_q.backup;
  assign entry_count_out_o    = 7'(count_q);
  assign version_out_o        = version_q;
  assign allocated_id_o       = alloc_q;

  `PTE_ASSERT_NEVER(a_count_max, clk_i, rst_ni, count_q > CW'(MAX_ENTRIES))
  `PTE_ASSERT_NEVER(a_one_txn, clk_i, rst_ni, in_ready_o && out_valid_q)
  `PTE_ASSERT_IMPLY(a_full_refuse, clk_i, rst_ni, out_valid_q && !ok_q,
                    count_q == CW'(MAX_ENTRIES))

endmodule
